// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the port checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds whenever the antecedent holds, checked in the same cycle.
`define VV_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Holds in the cycle after the antecedent.
`define VV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/vv_pkg.sv
// ----------------------------------------------------------------------------
// Velocity Verlet package
// Register indexes, field widths and a saturation helper.
// ----------------------------------------------------------------------------
package vv_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned MovedW = 31;
  localparam int unsigned CntW   = 17;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned AccW   = 72;

  localparam logic [IdxW-1:0] CfgMode      = 3'd0;
  localparam logic [IdxW-1:0] CfgTimeStep  = 3'd1;
  localparam logic [IdxW-1:0] CfgInvMass   = 3'd2;
  localparam logic [IdxW-1:0] CfgFriction  = 3'd3;
  localparam logic [IdxW-1:0] CfgRefLimit  = 3'd4;
  localparam logic [IdxW-1:0] CfgPartCount = 3'd5;

  localparam logic [CntW-1:0] CntMax = '1;

  typedef logic signed [AccW-1:0] acc_t;

  function automatic logic signed [DataW-1:0] sat_s32(input acc_t v);
    acc_t hi;
    acc_t lo;
    hi = AccW'(64'sd2147483647);
    lo = -AccW'(64'sd2147483648);
    if (v > hi) begin
      sat_s32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat_s32 = 32'sh80000000;
    end else begin
      sat_s32 = v[DataW-1:0];
    end
  endfunction

endpackage

// File: rtl/velocity_verlet_particle_update.sv
// ----------------------------------------------------------------------------
// One word per cycle from input word to output word while no stall holds the flow.
// Throughput is set by the six-stage multiply pipeline; stalls back up per stage.
// After reset or a configuration write, input stalls while the coefficient
// multipliers settle. Reset clears valids and the pass counters.
// ----------------------------------------------------------------------------
module velocity_verlet_particle_update #(
  parameter int unsigned MAX_PARTICLES = 65536,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vv_pkg::IdxW-1:0]       cfg_index_i,
  input  logic [vv_pkg::DataW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            pos_z_i,
  input  logic signed [31:0]            vel_x_i,
  input  logic signed [31:0]            vel_y_i,
  input  logic signed [31:0]            vel_z_i,
  input  logic signed [31:0]            force_x_i,
  input  logic signed [31:0]            force_y_i,
  input  logic signed [31:0]            force_z_i,
  input  logic [30:0]                   moved_x_i,
  input  logic [30:0]                   moved_y_i,
  input  logic [30:0]                   moved_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            new_x_o,
  output logic signed [31:0]            new_y_o,
  output logic signed [31:0]            new_z_o,
  output logic signed [31:0]            new_vx_o,
  output logic signed [31:0]            new_vy_o,
  output logic signed [31:0]            new_vz_o,
  output logic [30:0]                   new_moved_x_o,
  output logic [30:0]                   new_moved_y_o,
  output logic [30:0]                   new_moved_z_o,
  output logic                          over_limit_o,
  output logic [16:0]                   refresh_count_o,
  output logic                          pass_end_o
);

  localparam int unsigned W  = vv_pkg::DataW;
  localparam int unsigned MW = vv_pkg::MovedW;
  localparam int unsigned CW = vv_pkg::CntW;
  localparam int unsigned AW = vv_pkg::AccW;

  function automatic logic [W-1:0] coef(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input int unsigned sh);
    logic [2*W-1:0] p;
    p = (2*W)'(a) * (2*W)'(b);
    p = p >> sh;
    coef = (|p[2*W-1:W]) ? '1 : p[W-1:0];
  endfunction

  // Configuration registers.
  logic          mode_q;
  logic [W-1:0]  dt_q, im_q, fr_q, lim_q;
  logic [CW-1:0] pcnt_q;
  logic [1:0]    settle_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      dt_q     <= 32'd655;
      im_q     <= 32'd65536;
      fr_q     <= '0;
      lim_q    <= 32'd65536;
      pcnt_q   <= 17'd1;
      settle_q <= 2'd3;
    end else if (cfg_valid_i) begin
      settle_q <= 2'd3;
      case (cfg_index_i)
        vv_pkg::CfgMode:      mode_q <= cfg_data_i[0];
        vv_pkg::CfgTimeStep:  dt_q   <= cfg_data_i;
        vv_pkg::CfgInvMass:   im_q   <= cfg_data_i;
        vv_pkg::CfgFriction:  fr_q   <= cfg_data_i;
        vv_pkg::CfgRefLimit:  lim_q  <= cfg_data_i;
        vv_pkg::CfgPartCount: pcnt_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  // Coefficients in two registered rounds.
  logic [W-1:0] kick_q, dtsq_q, damp_q, kick2_q, fpos_q;

  always_ff @(posedge clk_i) begin
    kick_q  <= coef(dt_q, im_q, FRAC_BITS + 1);
    dtsq_q  <= coef(dt_q, dt_q, FRAC_BITS);
    damp_q  <= coef(fr_q, dt_q, FRAC_BITS + 1);
    kick2_q <= coef(dtsq_q, im_q, FRAC_BITS + 1);
    fpos_q  <= coef(dt_q, damp_q, FRAC_BITS);
  end

  // Stage valids and enables.
  logic [6:1] vld_q;
  logic [6:1] en;

  assign en[6] = !vld_q[6] || !out_stall_i;
  assign en[5] = !vld_q[5] || en[6];
  assign en[4] = !vld_q[4] || en[5];
  assign en[3] = !vld_q[3] || en[4];
  assign en[2] = !vld_q[2] || en[3];
  assign en[1] = !vld_q[1] || en[2];

  assign in_stall_o = !en[1] || (settle_q != 2'd0);

  logic acc_in;
  assign acc_in = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= acc_in;
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
      if (en[4]) vld_q[4] <= vld_q[3];
      if (en[5]) vld_q[5] <= vld_q[4];
      if (en[6]) vld_q[6] <= vld_q[5];
    end
  end

  logic signed [W-1:0] xin [3];
  logic signed [W-1:0] vin [3];
  logic signed [W-1:0] fin [3];
  logic [MW-1:0]       min_ [3];

  assign xin  = '{pos_x_i, pos_y_i, pos_z_i};
  assign vin  = '{vel_x_i, vel_y_i, vel_z_i};
  assign fin  = '{force_x_i, force_y_i, force_z_i};
  assign min_ = '{moved_x_i, moved_y_i, moved_z_i};

  // Stage 1: products.
  logic signed [W-1:0]  x1_q [3];
  logic signed [W-1:0]  v1_q [3];
  logic [MW-1:0]        m1_q [3];
  logic signed [2*W:0]  fk1_q [3], vdt1_q [3], fk21_q [3], vfp1_q [3], vd1_q [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        x1_q[k]   <= xin[k];
        v1_q[k]   <= vin[k];
        m1_q[k]   <= min_[k];
        fk1_q[k]  <= (2*W+1)'(fin[k]) * $signed({1'b0, kick_q});
        vdt1_q[k] <= (2*W+1)'(vin[k]) * $signed({1'b0, dt_q});
        fk21_q[k] <= (2*W+1)'(fin[k]) * $signed({1'b0, kick2_q});
        vfp1_q[k] <= (2*W+1)'(vin[k]) * $signed({1'b0, fpos_q});
        vd1_q[k]  <= (2*W+1)'(vin[k]) * $signed({1'b0, damp_q});
      end
    end
  end

  // Stage 2: velocity and friction-mode position sums.
  logic signed [W-1:0] x2_q [3], nv2_q [3], nxf2_q [3];
  logic [MW-1:0]       m2_q [3];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        x2_q[k]   <= x1_q[k];
        m2_q[k]   <= m1_q[k];
        nv2_q[k]  <= vv_pkg::sat_s32(AW'(v1_q[k]) + AW'(fk1_q[k] >>> FRAC_BITS)
                     - (mode_q ? AW'(vd1_q[k] >>> FRAC_BITS) : AW'(0)));
        nxf2_q[k] <= vv_pkg::sat_s32(AW'(x1_q[k]) + AW'(vdt1_q[k] >>> FRAC_BITS)
                     + AW'(fk21_q[k] >>> FRAC_BITS) - AW'(vfp1_q[k] >>> FRAC_BITS));
      end
    end
  end

  // Stage 3: drift product for plain mode.
  logic signed [W-1:0] x3_q [3], nv3_q [3], nxf3_q [3];
  logic [MW-1:0]       m3_q [3];
  logic signed [2*W:0] pnd3_q [3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        x3_q[k]   <= x2_q[k];
        m3_q[k]   <= m2_q[k];
        nv3_q[k]  <= nv2_q[k];
        nxf3_q[k] <= nxf2_q[k];
        pnd3_q[k] <= (2*W+1)'(nv2_q[k]) * $signed({1'b0, dt_q});
      end
    end
  end

  // Stage 4: position select and displacement accumulate.
  logic signed [W-1:0] nx4_q [3], nv4_q [3];
  logic [MW-1:0]       m4_q [3];
  logic signed [W-1:0] nx4 [3];
  logic signed [W:0]   d4 [3];
  logic [W:0]          ad4 [3];
  logic [W+1:0]        sm4 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nx4[k] = mode_q ? nxf3_q[k]
                      : vv_pkg::sat_s32(AW'(x3_q[k]) + AW'(pnd3_q[k] >>> FRAC_BITS));
      d4[k]  = (W+1)'(nx4[k]) - (W+1)'(x3_q[k]);
      ad4[k] = d4[k][W] ? (W+1)'(-d4[k]) : (W+1)'(d4[k]);
      sm4[k] = (W+2)'(m3_q[k]) + (W+2)'(ad4[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        nx4_q[k] <= nx4[k];
        nv4_q[k] <= nv3_q[k];
        m4_q[k]  <= (|sm4[k][W+1:MW]) ? '1 : sm4[k][MW-1:0];
      end
    end
  end

  // Stage 5: squares.
  logic signed [W-1:0] nx5_q [3], nv5_q [3];
  logic [MW-1:0]       m5_q [3];
  logic [2*MW-1:0]     sq5_q [3];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int k = 0; k < 3; k++) begin
        nx5_q[k] <= nx4_q[k];
        nv5_q[k] <= nv4_q[k];
        m5_q[k]  <= m4_q[k];
        sq5_q[k] <= (2*MW)'(m4_q[k]) * (2*MW)'(m4_q[k]);
      end
    end
  end

  // Stage 6: limit compare, pass counters, output register.
  logic [63:0]   sumsq;
  logic          over;
  logic [CW-1:0] lim_n;
  logic [CW-1:0] cnt_n;
  logic          pend;
  logic [CW-1:0] pos_q, oc_q;

  always_comb begin
    sumsq = 64'(sq5_q[0]) + 64'(sq5_q[1]) + 64'(sq5_q[2]);
    over  = sumsq > (64'(lim_q) << FRAC_BITS);
    cnt_n = (over && oc_q != vv_pkg::CntMax) ? oc_q + 1'b1 : oc_q;
    if (pcnt_q == '0) begin
      lim_n = CW'(1);
    end else if (64'(pcnt_q) > 64'(MAX_PARTICLES)) begin
      lim_n = CW'(MAX_PARTICLES);
    end else begin
      lim_n = pcnt_q;
    end
    pend = ((CW+1)'(pos_q) + 1'b1) >= (CW+1)'(lim_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      oc_q  <= '0;
    end else if (en[6] && vld_q[5]) begin
      pos_q <= pend ? '0 : pos_q + 1'b1;
      oc_q  <= pend ? '0 : cnt_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6] && vld_q[5]) begin
      new_x_o         <= nx5_q[0];
      new_y_o         <= nx5_q[1];
      new_z_o         <= nx5_q[2];
      new_vx_o        <= nv5_q[0];
      new_vy_o        <= nv5_q[1];
      new_vz_o        <= nv5_q[2];
      new_moved_x_o   <= m5_q[0];
      new_moved_y_o   <= m5_q[1];
      new_moved_z_o   <= m5_q[2];
      over_limit_o    <= over;
      refresh_count_o <= cnt_n;
      pass_end_o      <= pend;
    end
  end

  assign out_valid_o = vld_q[6];

endmodule

// File: rtl/vv_checker.sv
// ----------------------------------------------------------------------------
// Velocity Verlet port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vv_port_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        over_limit_o,
  input logic [16:0] refresh_count_o
);

  `VV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `VV_ASSERT_NOW(a_over_counted, clk_i, rst_ni, out_valid_o && over_limit_o, refresh_count_o != 17'd0)
  `VV_ASSERT_NEXT(a_cfg_settle, clk_i, rst_ni, cfg_valid_i && cfg_ready_o, in_stall_o)

endmodule

bind velocity_verlet_particle_update vv_port_props u_vv_port_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .over_limit_o    (over_limit_o),
  .refresh_count_o (refresh_count_o)
);

// File: dv/vv_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Particle update checker
// Watches the configuration, particle and result channels of the particle
// update block. It keeps its own copy of the registers and pass counters,
// predicts each result word from the accepted particle word, and compares
// the result words in order, field by field.
// ----------------------------------------------------------------------------
module vv_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [vv_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [vv_pkg::DataW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic signed [31:0]       pos_x_i,
  input  logic signed [31:0]       pos_y_i,
  input  logic signed [31:0]       pos_z_i,
  input  logic signed [31:0]       vel_x_i,
  input  logic signed [31:0]       vel_y_i,
  input  logic signed [31:0]       vel_z_i,
  input  logic signed [31:0]       force_x_i,
  input  logic signed [31:0]       force_y_i,
  input  logic signed [31:0]       force_z_i,
  input  logic [30:0]              moved_x_i,
  input  logic [30:0]              moved_y_i,
  input  logic [30:0]              moved_z_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [31:0]       new_x_i,
  input  logic signed [31:0]       new_y_i,
  input  logic signed [31:0]       new_z_i,
  input  logic signed [31:0]       new_vx_i,
  input  logic signed [31:0]       new_vy_i,
  input  logic signed [31:0]       new_vz_i,
  input  logic [30:0]              new_moved_x_i,
  input  logic [30:0]              new_moved_y_i,
  input  logic [30:0]              new_moved_z_i,
  input  logic                     over_limit_i,
  input  logic [16:0]              refresh_count_i,
  input  logic                     pass_end_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       checked_o
);

  localparam int FracBits = 16;
  localparam int MaxParticles = 65536;

  typedef struct {
    logic [31:0] pos[3];
    logic [31:0] vel[3];
    logic [30:0] moved[3];
    logic        over;
    logic [16:0] count;
    logic        last;
  } update_t;

  logic        mode_q;
  logic [31:0] dt_q;
  logic [31:0] inv_mass_q;
  logic [31:0] friction_q;
  logic [31:0] limit_q;
  logic [16:0] part_count_q;
  logic [16:0] pass_pos_q;
  logic [16:0] over_cnt_q;

  update_t expected_updates[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] clip_u32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Exact product of a signed value and an unsigned coefficient, floor shift.
  function automatic longint qscale(input longint a, input logic [31:0] b);
    longint p;
    p = a * longint'({32'b0, b});
    return p >>> FracBits;
  endfunction

  task automatic predict_update(input logic signed [31:0] px[3],
                                input logic signed [31:0] vx[3],
                                input logic signed [31:0] fx[3],
                                input logic [30:0] mx[3], output update_t r);
    logic [31:0] kick, dtsq, kick2, damp, fpos;
    logic [63:0] sumsq, mv;
    longint x, v, f, nx, nv, d;
    int unsigned lim;
    kick  = clip_u32(({32'b0, dt_q} * {32'b0, inv_mass_q}) >> (FracBits + 1));
    dtsq  = clip_u32(({32'b0, dt_q} * {32'b0, dt_q}) >> FracBits);
    kick2 = clip_u32(({32'b0, dtsq} * {32'b0, inv_mass_q}) >> (FracBits + 1));
    damp  = clip_u32(({32'b0, friction_q} * {32'b0, dt_q}) >> (FracBits + 1));
    fpos  = clip_u32(({32'b0, dt_q} * {32'b0, damp}) >> FracBits);
    sumsq = '0;
    for (int k = 0; k < 3; k++) begin
      x = px[k];
      v = vx[k];
      f = fx[k];
      if (!mode_q) begin
        nv = clamp32(v + qscale(f, kick));
        nx = clamp32(x + qscale(nv, dt_q));
      end else begin
        nx = clamp32(x + qscale(v, dt_q) + qscale(f, kick2) - qscale(v, fpos));
        nv = clamp32(v + qscale(f, kick) - qscale(v, damp));
      end
      d = nx - x;
      if (d < 0) d = -d;
      mv = {33'b0, mx[k]} + 64'(d);
      if (mv > 64'h7FFF_FFFF) mv = 64'h7FFF_FFFF;
      sumsq += mv * mv;
      r.pos[k] = nx[31:0];
      r.vel[k] = nv[31:0];
      r.moved[k] = mv[30:0];
    end
    r.over = sumsq > ({32'b0, limit_q} << FracBits);
    if (r.over && over_cnt_q != vv_pkg::CntMax) over_cnt_q++;
    lim = part_count_q;
    if (lim == 0) lim = 1;
    if (lim > MaxParticles) lim = MaxParticles;
    r.last = (pass_pos_q + 1) >= lim;
    r.count = over_cnt_q;
    if (r.last) begin
      pass_pos_q = '0;
      over_cnt_q = '0;
    end else begin
      pass_pos_q = pass_pos_q + 1;
    end
  endtask

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      if (errors_o < 10) begin
        $display("result %0d: %s expected %h, got %h", checked_o, name, want, got);
      end
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] px[3], vx[3], fx[3];
    logic [30:0] mx[3];
    logic [31:0] gp[3], gv[3];
    logic [30:0] gm[3];
    update_t r, e;
    if (!rst_ni) begin
      mode_q <= 1'b0;
      dt_q <= 32'd655;
      inv_mass_q <= 32'd65536;
      friction_q <= '0;
      limit_q <= 32'd65536;
      part_count_q <= 17'd1;
      pass_pos_q <= '0;
      over_cnt_q <= '0;
      expected_updates.delete();
      errors_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        px = '{pos_x_i, pos_y_i, pos_z_i};
        vx = '{vel_x_i, vel_y_i, vel_z_i};
        fx = '{force_x_i, force_y_i, force_z_i};
        mx = '{moved_x_i, moved_y_i, moved_z_i};
        predict_update(px, vx, fx, mx, r);
        expected_updates.push_back(r);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_updates.size() == 0) begin
          if (errors_o < 10) $display("result word with no particle pending");
          errors_o++;
        end else begin
          e = expected_updates.pop_front();
          gp = '{new_x_i, new_y_i, new_z_i};
          gv = '{new_vx_i, new_vy_i, new_vz_i};
          gm = '{new_moved_x_i, new_moved_y_i, new_moved_z_i};
          for (int k = 0; k < 3; k++) begin
            compare_field($sformatf("position[%0d]", k), e.pos[k], gp[k]);
            compare_field($sformatf("velocity[%0d]", k), e.vel[k], gv[k]);
            compare_field($sformatf("moved[%0d]", k), {1'b0, e.moved[k]}, {1'b0, gm[k]});
          end
          compare_field("over_limit", {31'b0, e.over}, {31'b0, over_limit_i});
          compare_field("refresh_count", {15'b0, e.count}, {15'b0, refresh_count_i});
          compare_field("pass_end", {31'b0, e.last}, {31'b0, pass_end_i});
        end
        checked_o++;
      end
      pending_o <= expected_updates.size();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          vv_pkg::CfgMode:      mode_q <= cfg_data_i[0];
          vv_pkg::CfgTimeStep:  dt_q <= cfg_data_i;
          vv_pkg::CfgInvMass:   inv_mass_q <= cfg_data_i;
          vv_pkg::CfgFriction:  friction_q <= cfg_data_i;
          vv_pkg::CfgRefLimit:  limit_q <= cfg_data_i;
          vv_pkg::CfgPartCount: part_count_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: dv/velocity_verlet_particle_update_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Particle update testbench
// Drives particle words and register writes into the particle update block
// with random gaps and output stalls, across plain and friction phases with
// extreme and random settings. A checker beside the block predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module velocity_verlet_particle_update_tb;

  localparam logic [vv_pkg::IdxW-1:0] CfgFirstUnused = vv_pkg::CfgPartCount + 3'd1;

  typedef struct {
    logic signed [31:0] pos[3];
    logic signed [31:0] vel[3];
    logic signed [31:0] frc[3];
    logic [30:0] moved[3];
  } particle_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [vv_pkg::IdxW-1:0] cfg_index_i = '0;
  logic [vv_pkg::DataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] pos_i[3] = '{default: '0};
  logic signed [31:0] vel_i[3] = '{default: '0};
  logic signed [31:0] frc_i[3] = '{default: '0};
  logic [30:0] moved_i[3] = '{default: '0};
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] new_x_o, new_y_o, new_z_o, new_vx_o, new_vy_o, new_vz_o;
  logic [30:0] new_moved_x_o, new_moved_y_o, new_moved_z_o;
  logic over_limit_o;
  logic [16:0] refresh_count_o;
  logic pass_end_o;
  int errors, pending, checked;
  int sent = 0;
  int phases = 0;
  bit no_idle = 1'b0;

  velocity_verlet_particle_update uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .pos_x_i(pos_i[0]), .pos_y_i(pos_i[1]), .pos_z_i(pos_i[2]),
    .vel_x_i(vel_i[0]), .vel_y_i(vel_i[1]), .vel_z_i(vel_i[2]),
    .force_x_i(frc_i[0]), .force_y_i(frc_i[1]), .force_z_i(frc_i[2]),
    .moved_x_i(moved_i[0]), .moved_y_i(moved_i[1]), .moved_z_i(moved_i[2]),
    .out_valid_o, .out_stall_i, .new_x_o, .new_y_o, .new_z_o,
    .new_vx_o, .new_vy_o, .new_vz_o, .new_moved_x_o, .new_moved_y_o, .new_moved_z_o,
    .over_limit_o, .refresh_count_o, .pass_end_o
  );

  vv_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .pos_x_i(pos_i[0]), .pos_y_i(pos_i[1]), .pos_z_i(pos_i[2]),
    .vel_x_i(vel_i[0]), .vel_y_i(vel_i[1]), .vel_z_i(vel_i[2]),
    .force_x_i(frc_i[0]), .force_y_i(frc_i[1]), .force_z_i(frc_i[2]),
    .moved_x_i(moved_i[0]), .moved_y_i(moved_i[1]), .moved_z_i(moved_i[2]),
    .out_valid_i(out_valid_o), .out_stall_i,
    .new_x_i(new_x_o), .new_y_i(new_y_o), .new_z_i(new_z_o),
    .new_vx_i(new_vx_o), .new_vy_i(new_vy_o), .new_vz_i(new_vz_o),
    .new_moved_x_i(new_moved_x_o), .new_moved_y_i(new_moved_y_o),
    .new_moved_z_i(new_moved_z_o), .over_limit_i(over_limit_o),
    .refresh_count_i(refresh_count_o), .pass_end_i(pass_end_o),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("velocity_verlet_particle_update: mismatch");
    $finish;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3: return 32'($signed($urandom_range(0, 33554431)) - 16777216);
      default: return 32'($signed($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  function automatic logic [30:0] pick_moved();
    case ($urandom_range(0, 3))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 131072));
      2: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
      default: return 31'($urandom_range(0, 1048576));
    endcase
  endfunction

  task automatic send_particle(input particle_t p);
    int gap;
    bit busy;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pos_i <= p.pos;
    vel_i <= p.vel;
    frc_i <= p.frc;
    moved_i <= p.moved;
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      busy = in_stall_o;
      @(posedge clk_i);
    end while (busy);
    sent++;
  endtask

  task automatic send_random(input int n);
    particle_t p;
    repeat (n) begin
      for (int k = 0; k < 3; k++) begin
        p.pos[k] = pick_word();
        p.vel[k] = pick_word();
        p.frc[k] = pick_word();
        p.moved[k] = pick_moved();
      end
      send_particle(p);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [vv_pkg::IdxW-1:0] idx, input logic [31:0] val);
    bit ok;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_phase(input logic md, input logic [31:0] dt, input logic [31:0] im,
                           input logic [31:0] fr, input logic [31:0] lim,
                           input logic [31:0] cnt);
    drain();
    write_reg(vv_pkg::CfgMode, {$urandom() & 32'hFFFF_FFFE, md});
    write_reg(vv_pkg::CfgTimeStep, dt);
    write_reg(vv_pkg::CfgInvMass, im);
    write_reg(vv_pkg::CfgFriction, fr);
    write_reg(vv_pkg::CfgRefLimit, lim);
    write_reg(vv_pkg::CfgPartCount, cnt);
    // Writes past the register list must leave every setting alone.
    write_reg(CfgFirstUnused + 3'($urandom_range(0, 1)), $urandom());
    no_idle = ($urandom_range(0, 3) == 0);
    phases++;
  endtask

  initial begin
    int g;
    bit got;
    forever begin
      g = no_idle ? 0 : $urandom_range(0, 8);
      repeat (g) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(posedge clk_i);
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        got = out_valid_o;
        @(posedge clk_i);
      end while (!got);
    end
  end

  initial begin
    particle_t p;
    logic [31:0] edge_vals[4];
    edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: every field at its extremes, mixed signs and saturation.
    for (int i = 0; i < 16; i++) begin
      for (int k = 0; k < 3; k++) begin
        p.pos[k] = edge_vals[(i + k) % 4];
        p.vel[k] = edge_vals[(i / 4 + k) % 4];
        p.frc[k] = edge_vals[(i + 2 * k) % 4];
        p.moved[k] = (i % 3 == k) ? 31'h7FFF_FFFF : 31'(i * 4096);
      end
      send_particle(p);
    end
    set_phase(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'd0);
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 3; k++) begin
        p.pos[k] = edge_vals[(i + k) % 4];
        p.vel[k] = edge_vals[(i + 1) % 4];
        p.frc[k] = edge_vals[(i + 3 * k) % 4];
        p.moved[k] = 31'h7FFF_FFFF;
      end
      send_particle(p);
    end

    set_phase(1'b0, 32'd655, 32'd65536, 32'd0, 32'd65536, 32'd7);
    send_random(150);
    set_phase(1'b1, 32'd655, 32'd65536, 32'd13107, 32'd65536, 32'd5);
    send_random(150);
    set_phase(1'b0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'd65536);
    send_random(120);
    set_phase(1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'd1000, 32'd65537);
    send_random(120);
    set_phase(1'b0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 32'd131071);
    send_random(100);
    set_phase(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_random(100);

    // Pass length lowered in the middle of a pass.
    set_phase(1'b0, 32'd3000, 32'd65536, 32'd0, 32'd40000, 32'd40);
    send_random(25);
    set_phase(1'b1, 32'd3000, 32'd65536, 32'd20000, 32'd40000, 32'd3);
    send_random(60);

    repeat (8) begin
      set_phase(1'($urandom()), $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 8192),
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 262144),
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 131072),
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000000),
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20));
      send_random(120);
    end

    drain();
    $display("Sent %0d particles over %0d register phases, plain and friction modes;",
             sent, phases);
    $display("%0d result words compared, %0d differences.", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("velocity_verlet_particle_update: match");
    end else begin
      $display("velocity_verlet_particle_update: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/vv_pkg.sv
rtl/velocity_verlet_particle_update.sv
rtl/vv_checker.sv
dv/vv_checker.sv
dv/velocity_verlet_particle_update_tb.sv
